// File: hdl/ppu_scroll_address_timing_core_macros.svh
// assertion macros shared by the scroll address timing rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef PPU_SCROLL_ADDRESS_TIMING_CORE_MACROS_SVH
`define PPU_SCROLL_ADDRESS_TIMING_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SAT_ASSERT(lbl, prop, msg)
`define SAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/ppu_sat_pkg.sv
// types and constants of the scroll address timing block
// no dependencies
package ppu_sat_pkg;

  // frame geometry, lines kept as row = line + 1
  localparam logic [8:0] LastDot       = 9'd340;
  localparam logic [8:0] LastRow       = 9'd261;
  localparam logic [8:0] PreRow        = 9'd0;
  localparam logic [8:0] FirstRow      = 9'd1;
  localparam logic [8:0] LastRenderRow = 9'd240;
  localparam logic [8:0] VblankRow     = 9'd242;
  localparam logic [8:0] FlagDot       = 9'd1;

  // scroll update dots
  localparam logic [8:0] CxFirstDot    = 9'd8;
  localparam logic [8:0] YIncDot       = 9'd256;
  localparam logic [8:0] PrefetchDotA  = 9'd328;
  localparam logic [8:0] PrefetchDotB  = 9'd336;
  localparam logic [8:0] HcopyDot      = 9'd257;
  localparam logic [8:0] VcopyFirstDot = 9'd280;
  localparam logic [8:0] VcopyEndDot   = 9'd305;

  localparam logic [4:0] CoarseMax     = 5'd31;
  localparam logic [4:0] CoarseYFlip   = 5'd29;
  localparam logic [2:0] FineYMax      = 3'd7;

  localparam logic [14:0] MaskHoriz    = 15'h041F;
  localparam logic [14:0] MaskVert     = 15'h7BE0;
  localparam logic [13:0] TileBase     = 14'h2000;
  localparam logic [13:0] AttrBase     = 14'h23C0;

  typedef struct packed {
    logic        rendering_enabled;
    logic [14:0] temp_address;
    logic        nmi_enable;
  } in_word_t;

  typedef struct packed {
    logic signed [9:0] line_number;
    logic [8:0]        dot_number;
    logic [14:0]       scroll_address;
    logic [13:0]       tile_fetch_address;
    logic [13:0]       attr_fetch_address;
    logic [1:0]        attr_quadrant;
    logic              vblank_flag;
    logic              nmi_pulse;
    logic              frame_done;
  } out_word_t;

  typedef struct packed {
    logic coarse_x;
    logic y_inc;
    logic h_copy;
    logic v_copy;
  } scroll_ctl_t;

  typedef struct packed {
    logic signed [9:0] line_number;
    logic [8:0]        dot_number;
    logic              vblank_flag;
    logic              nmi_pulse;
    logic              frame_done;
  } tick_t;

  typedef struct packed {
    logic [14:0] scroll_address;
    logic [13:0] tile_fetch_address;
    logic [13:0] attr_fetch_address;
    logic [1:0]  attr_quadrant;
  } fetch_t;

endpackage

// File: hdl/ppu_sat_in_if.sv
// input channel of the scroll address timing block
// depends on ppu_sat_pkg
interface ppu_sat_in_if;
  logic                 valid;
  logic                 ready;
  ppu_sat_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/ppu_sat_out_if.sv
// result channel of the scroll address timing block
// depends on ppu_sat_pkg
interface ppu_sat_out_if;
  logic                  valid;
  logic                  ready;
  ppu_sat_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/ppu_sat_timing.sv
// dot and line counters, frame parity, vblank flag and scroll update strobes
// depends on ppu_sat_pkg and the assertion macro header
`include "ppu_scroll_address_timing_core_macros.svh"

module ppu_sat_timing (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     render_i,
  input  logic                     nmi_en_i,
  output ppu_sat_pkg::tick_t       tick_o,
  output ppu_sat_pkg::scroll_ctl_t ctl_o
);

  logic [8:0] dot_q, dot_d;
  logic [8:0] row_q, row_d;
  logic       odd_q, odd_d;
  logic       vblank_q, vblank_d;
  logic       skip;
  logic [8:0] dot;
  logic       on_step;
  logic       cx_dot;
  logic       last_dot;
  logic       last_row;
  logic       flag_dot;

  always_comb begin
    // odd frames drop dot 0 of line 0 while rendering
    skip     = (row_q == ppu_sat_pkg::FirstRow) && (dot_q == '0) && odd_q && render_i;
    dot      = skip ? ppu_sat_pkg::FlagDot : dot_q;
    on_step  = (row_q <= ppu_sat_pkg::LastRenderRow) && render_i;
    cx_dot   = (dot[2:0] == 3'd0) &&
               (((dot >= ppu_sat_pkg::CxFirstDot) && (dot <= ppu_sat_pkg::YIncDot)) ||
                (dot == ppu_sat_pkg::PrefetchDotA) || (dot == ppu_sat_pkg::PrefetchDotB));
    flag_dot = (dot == ppu_sat_pkg::FlagDot);
    last_dot = (dot == ppu_sat_pkg::LastDot);
    last_row = (row_q == ppu_sat_pkg::LastRow);

    ctl_o.coarse_x = on_step && cx_dot;
    ctl_o.y_inc    = on_step && (dot == ppu_sat_pkg::YIncDot);
    ctl_o.h_copy   = on_step && (dot == ppu_sat_pkg::HcopyDot);
    ctl_o.v_copy   = on_step && (row_q == ppu_sat_pkg::PreRow) &&
                     (dot >= ppu_sat_pkg::VcopyFirstDot) && (dot < ppu_sat_pkg::VcopyEndDot);

    vblank_d = vblank_q;
    if ((row_q == ppu_sat_pkg::PreRow) && flag_dot) begin
      vblank_d = 1'b0;
    end
    if ((row_q == ppu_sat_pkg::VblankRow) && flag_dot) begin
      vblank_d = 1'b1;
    end

    dot_d = last_dot ? 9'd0 : dot + 9'd1;
    row_d = row_q;
    if (last_dot) begin
      row_d = last_row ? ppu_sat_pkg::PreRow : row_q + 9'd1;
    end
    odd_d = odd_q ^ (last_dot && last_row);

    tick_o.line_number = $signed({1'b0, row_q}) - 10'sd1;
    tick_o.dot_number  = dot;
    tick_o.vblank_flag = vblank_d;
    tick_o.nmi_pulse   = (row_q == ppu_sat_pkg::VblankRow) && flag_dot && nmi_en_i;
    tick_o.frame_done  = last_dot && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q    <= '0;
      row_q    <= ppu_sat_pkg::PreRow;
      odd_q    <= 1'b0;
      vblank_q <= 1'b1;
    end else if (adv_i) begin
      dot_q    <= dot_d;
      row_q    <= row_d;
      odd_q    <= odd_d;
      vblank_q <= vblank_d;
    end
  end

  `SAT_ASSERT(a_frame_wrap, (adv_i && last_dot && last_row) |=> ((row_q == ppu_sat_pkg::PreRow) && (odd_q != $past(odd_q))), "frame end did not wrap rows and flip parity")
  `SAT_ASSERT(a_vblank_set, (adv_i && (row_q == ppu_sat_pkg::VblankRow) && flag_dot) |=> vblank_q, "vblank not set at start of vblank line")
  `SAT_ASSERT(a_skip_lands, (adv_i && skip) |=> (dot_q == 9'd2), "odd frame skip did not advance past dot 1")
  `SAT_ASSERT(a_update_rows, (ctl_o.y_inc || ctl_o.h_copy || ctl_o.coarse_x) |-> (row_q <= ppu_sat_pkg::LastRenderRow), "scroll update outside rendering lines")

endmodule

// File: hdl/ppu_sat_scroll.sv
// current scroll address register with its increments and copies
// depends on ppu_sat_pkg
module ppu_sat_scroll (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  ppu_sat_pkg::scroll_ctl_t ctl_i,
  input  logic [14:0]              temp_i,
  output ppu_sat_pkg::fetch_t      fetch_o
);

  logic [14:0] v_q, v_d;
  logic [14:0] v_cx;
  logic [14:0] v_y;
  logic [14:0] v_h;
  logic [4:0]  cy;

  always_comb begin
    v_cx = v_q;
    if (ctl_i.coarse_x) begin
      if (v_q[4:0] == ppu_sat_pkg::CoarseMax) begin
        v_cx[4:0] = 5'd0;
        v_cx[10]  = ~v_q[10];
      end else begin
        v_cx[4:0] = v_q[4:0] + 5'd1;
      end
    end

    // fine y first, then coarse y with the attribute-row wrap at 29
    v_y = v_cx;
    cy  = v_cx[9:5];
    if (ctl_i.y_inc) begin
      if (v_cx[14:12] != ppu_sat_pkg::FineYMax) begin
        v_y[14:12] = v_cx[14:12] + 3'd1;
      end else begin
        v_y[14:12] = 3'd0;
        if (cy == ppu_sat_pkg::CoarseYFlip) begin
          v_y[9:5] = 5'd0;
          v_y[11]  = ~v_cx[11];
        end else if (cy == ppu_sat_pkg::CoarseMax) begin
          v_y[9:5] = 5'd0;
        end else begin
          v_y[9:5] = cy + 5'd1;
        end
      end
    end

    v_h = ctl_i.h_copy ? ((v_y & ~ppu_sat_pkg::MaskHoriz) | (temp_i & ppu_sat_pkg::MaskHoriz))
                       : v_y;
    v_d = ctl_i.v_copy ? ((v_h & ~ppu_sat_pkg::MaskVert) | (temp_i & ppu_sat_pkg::MaskVert))
                       : v_h;

    fetch_o.scroll_address     = v_q;
    fetch_o.tile_fetch_address = ppu_sat_pkg::TileBase | {2'b00, v_q[11:0]};
    fetch_o.attr_fetch_address = ppu_sat_pkg::AttrBase |
                                 {2'b00, v_q[11:10], 4'b0000, v_q[9:7], v_q[4:2]};
    fetch_o.attr_quadrant      = {v_q[6], v_q[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= v_d;
    end
  end

endmodule

// File: hdl/ppu_scroll_address_timing_core.sv
// Dot tick timing and scroll address unit. Each input word is one dot tick and yields
// exactly one result word. A word is accepted every clock cycle unless out_o stalls;
// its result passes the input register, then the result register. The rate is
// set by the update loop of the dot/line counters and the scroll address.
// After reset the block sits on the pre-render line, dot 0, even frame, vblank set.
// depends on ppu_sat_pkg, ppu_sat_in_if, ppu_sat_out_if, ppu_sat_timing, ppu_sat_scroll
`include "ppu_scroll_address_timing_core_macros.svh"

module ppu_scroll_address_timing_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  ppu_sat_in_if.sink          in_i,
  ppu_sat_out_if.source       out_o
);

  logic                   in_valid_q;
  ppu_sat_pkg::in_word_t  in_q;
  logic                   out_valid_q;
  ppu_sat_pkg::out_word_t out_q, out_d;
  logic                   advance;
  logic                   in_ready;
  logic                   out_ready;
  ppu_sat_pkg::tick_t       tick;
  ppu_sat_pkg::scroll_ctl_t ctl;
  ppu_sat_pkg::fetch_t      fetch;

  assign out_ready   = out_o.ready;
  assign advance     = in_valid_q && (!out_valid_q || out_ready);
  assign in_ready    = !in_valid_q || advance;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  ppu_sat_timing u_timing (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (advance),
    .render_i (in_q.rendering_enabled),
    .nmi_en_i (in_q.nmi_enable),
    .tick_o   (tick),
    .ctl_o    (ctl)
  );

  ppu_sat_scroll u_scroll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (advance),
    .ctl_i   (ctl),
    .temp_i  (in_q.temp_address),
    .fetch_o (fetch)
  );

  always_comb begin
    out_d.line_number        = tick.line_number;
    out_d.dot_number         = tick.dot_number;
    out_d.scroll_address     = fetch.scroll_address;
    out_d.tile_fetch_address = fetch.tile_fetch_address;
    out_d.attr_fetch_address = fetch.attr_fetch_address;
    out_d.attr_quadrant      = fetch.attr_quadrant;
    out_d.vblank_flag        = tick.vblank_flag;
    out_d.nmi_pulse          = tick.nmi_pulse;
    out_d.frame_done         = tick.frame_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  `SAT_ASSERT(a_adv_fills_out, advance |=> out_valid_q, "processed word did not reach result register")
  `SAT_ASSERT(a_empty_takes, !in_valid_q |-> in_ready, "empty input register refused a word")
  `SAT_ASSERT(a_stall_blocks, (out_valid_q && !out_ready) |-> !advance, "result overwritten while stalled")

endmodule

// File: tb/sv/ppu_scroll_address_timing_core_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the scroll address timing core: walks about a thousand dots
// through the block and checks every result word against a dot-by-dot predictor
// depends on ppu_sat_pkg, ppu_sat_in_if, ppu_sat_out_if and ppu_scroll_address_timing_core
module ppu_scroll_address_timing_core_tb;

  typedef struct packed {
    logic [8:0]        dot;
    logic signed [9:0] line;
    logic              odd;
    logic [14:0]       scroll;
    logic              vblank;
  } dot_state_t;

  typedef enum int {LineDark, LineNoisy, LineLit} line_mode_e;
  typedef enum int {RxFree, RxLight, RxHeavy} rx_mode_e;

  localparam dot_state_t PowerUpState = '{9'd0, -10'sd1, 1'b0, 15'd0, 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni;

  ppu_sat_in_if  in_if ();
  ppu_sat_out_if out_if ();

  ppu_scroll_address_timing_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ppu_sat_pkg::in_word_t  tick_q[$];
  ppu_sat_pkg::out_word_t dot_result_q[$];
  dot_state_t             model_st;
  int                     err_count = 0;

  always #5 clk_i = ~clk_i;

  // one dot of the timing and scroll logic; nxt is the state after the dot
  function automatic ppu_sat_pkg::out_word_t advance_dot(input dot_state_t cur,
                                                         input ppu_sat_pkg::in_word_t w,
                                                         output dot_state_t nxt);
    ppu_sat_pkg::out_word_t r;
    logic [8:0]  dot;
    logic [14:0] v;
    logic [14:0] t;
    logic [4:0]  cy;
    int          ln;
    nxt = cur;
    ln  = cur.line;
    dot = cur.dot;
    // odd frames drop dot 0 of line 0 while rendering
    if (ln == 0 && dot == 9'd0 && cur.odd && w.rendering_enabled) dot = ppu_sat_pkg::FlagDot;
    v = cur.scroll;
    t = w.temp_address;

    r.line_number        = ln[9:0];
    r.dot_number         = dot;
    r.scroll_address     = v;
    r.tile_fetch_address = ppu_sat_pkg::TileBase | {2'b00, v[11:0]};
    r.attr_fetch_address = ppu_sat_pkg::AttrBase |
                           {2'b00, v[11:10], 4'b0000, v[9:7], v[4:2]};
    r.attr_quadrant      = {v[6], v[1]};
    r.nmi_pulse          = 1'b0;
    r.frame_done         = 1'b0;

    if (ln == -1 && dot == ppu_sat_pkg::FlagDot) nxt.vblank = 1'b0;
    if (ln < 240 && w.rendering_enabled) begin
      if (dot[2:0] == 3'd0 &&
          ((dot >= ppu_sat_pkg::CxFirstDot && dot <= ppu_sat_pkg::YIncDot) ||
           dot == ppu_sat_pkg::PrefetchDotA || dot == ppu_sat_pkg::PrefetchDotB)) begin
        if (v[4:0] == ppu_sat_pkg::CoarseMax) begin
          v[4:0] = 5'd0;
          v[10]  = ~v[10];
        end else begin
          v[4:0] = v[4:0] + 5'd1;
        end
      end
      if (dot == ppu_sat_pkg::YIncDot) begin
        if (v[14:12] != ppu_sat_pkg::FineYMax) begin
          v[14:12] = v[14:12] + 3'd1;
        end else begin
          v[14:12] = 3'd0;
          cy = v[9:5];
          if (cy == ppu_sat_pkg::CoarseYFlip) begin
            cy    = 5'd0;
            v[11] = ~v[11];
          end else if (cy == ppu_sat_pkg::CoarseMax) begin
            cy = 5'd0;
          end else begin
            cy = cy + 5'd1;
          end
          v[9:5] = cy;
        end
      end
      if (dot == ppu_sat_pkg::HcopyDot)
        v = (v & ~ppu_sat_pkg::MaskHoriz) | (t & ppu_sat_pkg::MaskHoriz);
      if (ln == -1 && dot >= ppu_sat_pkg::VcopyFirstDot && dot < ppu_sat_pkg::VcopyEndDot)
        v = (v & ~ppu_sat_pkg::MaskVert) | (t & ppu_sat_pkg::MaskVert);
    end
    nxt.scroll = v;

    if (ln == 241 && dot == ppu_sat_pkg::FlagDot) begin
      nxt.vblank  = 1'b1;
      r.nmi_pulse = w.nmi_enable;
    end

    if (dot == ppu_sat_pkg::LastDot) begin
      nxt.dot = 9'd0;
      if (ln == 260) begin
        r.frame_done = 1'b1;
        nxt.line     = -10'sd1;
        nxt.odd      = ~cur.odd;
      end else begin
        nxt.line = 10'(ln + 1);
      end
    end else begin
      nxt.dot = dot + 9'd1;
    end
    r.vblank_flag = nxt.vblank;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // dot ticks: a short directed run on the pre-render line, then random lines
  initial begin : stimulus
    dot_state_t             plan;
    dot_state_t             plan_nxt;
    ppu_sat_pkg::in_word_t  w;
    ppu_sat_pkg::out_word_t unused;
    line_mode_e             mode;
    logic [14:0]            line_t;
    int                     frames;
    plan   = PowerUpState;
    frames = 0;
    mode   = LineLit;
    line_t = '0;
    for (int k = 0; k < 20; k++) begin
      w.rendering_enabled = k[1];
      w.temp_address      = (k >= 12) ? (k[0] ? 15'h5555 : 15'h2AAA) :
                            (k[0] ? 15'h7FFF : 15'h0000);
      w.nmi_enable        = k[2];
      tick_q.push_back(w);
      unused = advance_dot(plan, w, plan_nxt);
      plan   = plan_nxt;
    end
    while (tick_q.size() < 1000) begin
      if (plan.dot == 9'd0) begin
        case ($urandom_range(0, 9))
          0:       mode = LineDark;
          1:       mode = LineNoisy;
          default: mode = LineLit;
        endcase
        line_t = 15'($urandom);
        // steer coarse y near the wrap points half of the time
        if ($urandom_range(0, 1) == 1) line_t[9:5] = 5'($urandom_range(28, 31));
      end else if ($urandom_range(0, 63) == 0) begin
        line_t = 15'($urandom);
      end
      case (mode)
        LineDark:  w.rendering_enabled = 1'b0;
        LineNoisy: w.rendering_enabled = 1'($urandom_range(0, 1));
        default:   w.rendering_enabled = 1'b1;
      endcase
      if (plan.line == 10'sd0 && plan.dot == 9'd0 && plan.odd)
        w.rendering_enabled = (frames == 1);
      w.temp_address = line_t;
      if (plan.line == 10'sd241 && plan.dot == ppu_sat_pkg::FlagDot)
        w.nmi_enable = (frames % 2 == 0);
      else w.nmi_enable = 1'($urandom_range(0, 1));
      tick_q.push_back(w);
      unused = advance_dot(plan, w, plan_nxt);
      if (unused.frame_done) frames++;
      plan = plan_nxt;
    end
  end

  // sender: bursts of random length with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      burst_left  = 8;
      gap_left    = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0 || tick_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid <= 1'b1;
        in_if.data  <= tick_q.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(500, 3000);
          else burst_left = $urandom_range(1, 64);
          gap_left = $urandom_range(0, 6);
        end
      end
    end
  end

  // receiver: stretches of free, light and heavy stalling, plus one long hold-off
  rx_mode_e rx_mode;
  int       stretch_left;
  int       hold_left;
  int       rx_seen;
  logic     hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_ready;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode      = RxFree;
      stretch_left = 0;
      hold_left    = 0;
      rx_seen      = 0;
      hold_done    = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) rx_seen++;
      if (!hold_done && rx_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 300);
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
      end else begin
        stretch_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (rx_mode)
          RxFree:  next_ready = 1'b1;
          RxLight: next_ready = ($urandom_range(0, 3) != 0);
          default: next_ready = 1'($urandom_range(0, 1));
        endcase
      end
      out_if.ready <= next_ready;
    end
  end

  // monitor: predict on each accepted dot, compare each accepted result word
  always @(posedge clk_i or negedge rst_ni) begin
    dot_state_t             st_nxt;
    ppu_sat_pkg::out_word_t want;
    ppu_sat_pkg::out_word_t got;
    if (!rst_ni) begin
      model_st <= PowerUpState;
    end else begin
      if (in_if.valid && in_if.ready) begin
        want = advance_dot(model_st, in_if.data, st_nxt);
        model_st <= st_nxt;
        dot_result_q.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (dot_result_q.size() == 0) begin
          $error("result word with no expectation pending");
          err_count++;
        end else begin
          want = dot_result_q.pop_front();
          check_field("line_number", $signed(want.line_number), $signed(got.line_number));
          check_field("dot_number", want.dot_number, got.dot_number);
          check_field("scroll_address", want.scroll_address, got.scroll_address);
          check_field("tile_fetch_address", want.tile_fetch_address,
                      got.tile_fetch_address);
          check_field("attr_fetch_address", want.attr_fetch_address,
                      got.attr_fetch_address);
          check_field("attr_quadrant", want.attr_quadrant, got.attr_quadrant);
          check_field("vblank_flag", want.vblank_flag, got.vblank_flag);
          check_field("nmi_pulse", want.nmi_pulse, got.nmi_pulse);
          check_field("frame_done", want.frame_done, got.frame_done);
        end
      end
    end
  end

  initial begin : run_ctrl
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_if.valid || dot_result_q.size() != 0)
      @(negedge clk_i);
    // leave room for any stray word
    repeat (10) @(negedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ppu_sat_pkg.sv
hdl/ppu_sat_in_if.sv
hdl/ppu_sat_out_if.sv
hdl/ppu_sat_timing.sv
hdl/ppu_sat_scroll.sv
hdl/ppu_scroll_address_timing_core.sv
tb/sv/ppu_scroll_address_timing_core_tb.sv
